// File: sv/vpe_pkg.sv
// vpe_pkg: sizes, controller state type and the command/status structs
// shared by the variogram pair emitter modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vpe_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int IDX_W       = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

   localparam int TIME_W = 32;
   localparam int VAL_W  = 24;
   localparam int LAG_W  = 32;
   localparam int SV_W   = 2 * VAL_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // take the request transaction
      logic issue;       // read one stored sample and push a pair row
      logic issue_zero;  // push the closing (0,0) row
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rows_nz;     // the taken request has pair rows
      logic close_row;   // the taken request ends with a (0,0) row
      logic idx_last;    // read index points at the last pair row
      logic pipe_empty;  // no row in flight before the output register
   } status_type;

endpackage

`default_nettype wire

// File: sv/vpe_ram.sv
// vpe_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module vpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/vpe_ctrl.sv
// vpe_ctrl: sequencer for the pair emitter, drives commands to the datapath
// depends on vpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module vpe_ctrl
   import vpe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      busy           = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.rows_nz) begin
               state_in = ST_ISSUE;
            end else if (status.close_row) begin
               cmd.issue_zero = 1'b1;
               state_in       = ST_DRAIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/vpe_dp.sv
// vpe_dp: sample stores, sample count, read index and the row pipeline
// depends on vpe_pkg and vpe_ram
`timescale 1ns / 1ps
`default_nettype none

module vpe_dp
   import vpe_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic signed [TIME_W-1:0] req_sample_time,
   input  wire logic signed [VAL_W-1:0]  req_sample_value,
   input  wire logic                     req_has_sample,
   input  wire logic                     req_subject_end,
   output status_type                    status,
   output logic                          rsp_valid,
   output logic             [LAG_W-1:0]  rsp_lag,
   output logic             [SV_W-1:0]   rsp_semivariance,
   output logic                          rsp_run_last
);

   // subject bookkeeping
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_rows_ff, n_rows_in;
   logic             close_ff, close_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             pair;
   logic [CNT_W-1:0] cnt_after;

   logic signed [TIME_W-1:0] t_ff;
   logic signed [VAL_W-1:0]  y_ff;

   // store read data
   logic [TIME_W-1:0] t_rd;
   logic [VAL_W-1:0]  y_rd;

   // pipeline
   logic v0_ff, last0_ff, zero0_ff;
   logic v1_ff, last1_ff;
   logic [LAG_W-1:0] dt_abs_ff, dt_abs_in;
   logic [VAL_W-1:0] dy_abs_ff, dy_abs_in;
   logic             valid_ff, run_last_ff;
   logic [LAG_W-1:0] lag_ff;
   logic [SV_W-1:0]  sv_ff;
   logic [SV_W-1:0]  sq;

   logic signed [TIME_W:0] dt;
   logic signed [VAL_W:0]  dy;

   assign pair = req_has_sample && (count_ff < CNT_W'(MAX_SAMPLES));
   assign cnt_after = count_ff + CNT_W'(pair);

   always_comb begin
      count_in  = count_ff;
      n_rows_in = n_rows_ff;
      close_in  = close_ff;
      idx_in    = idx_ff;
      if (cmd.load) begin
         n_rows_in = pair ? count_ff : '0;
         close_in  = req_subject_end && (cnt_after <= CNT_W'(1));
         count_in  = req_subject_end ? '0 : cnt_after;
         idx_in    = '0;
      end else if (cmd.issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         n_rows_ff   <= '0;
         close_ff    <= 1'b0;
         idx_ff      <= '0;
         v0_ff       <= 1'b0;
         v1_ff       <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         count_ff    <= count_in;
         n_rows_ff   <= n_rows_in;
         close_ff    <= close_in;
         idx_ff      <= idx_in;
         v0_ff       <= cmd.issue || cmd.issue_zero;
         v1_ff       <= v0_ff;
         valid_ff    <= v1_ff;
      end
   end

   vpe_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SAMPLES)) u_time_ram (
      .clock   (clock),
      .wr_en   (cmd.load && pair),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_sample_time),
      .rd_en   (cmd.issue),
      .rd_addr (idx_ff),
      .rd_data (t_rd)
   );

   vpe_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SAMPLES)) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.load && pair),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_sample_value),
      .rd_en   (cmd.issue),
      .rd_addr (idx_ff),
      .rd_data (y_rd)
   );

   // differences against the new sample, zero for the closing row
   always_comb begin
      dt = $signed({t_rd[TIME_W-1], t_rd}) - $signed({t_ff[TIME_W-1], t_ff});
      dy = $signed({y_rd[VAL_W-1], y_rd}) - $signed({y_ff[VAL_W-1], y_ff});
      dt_abs_in = dt[TIME_W] ? LAG_W'(-dt) : LAG_W'(dt);
      dy_abs_in = dy[VAL_W] ? VAL_W'(-dy) : VAL_W'(dy);
      if (zero0_ff) begin
         dt_abs_in = '0;
         dy_abs_in = '0;
      end
   end

   assign sq = dy_abs_ff * dy_abs_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff <= req_sample_time;
         y_ff <= req_sample_value;
      end
      last0_ff    <= cmd.issue_zero || status.idx_last;
      zero0_ff    <= cmd.issue_zero;
      last1_ff    <= last0_ff;
      dt_abs_ff   <= dt_abs_in;
      dy_abs_ff   <= dy_abs_in;
      run_last_ff <= last1_ff;
      lag_ff      <= dt_abs_ff;
      sv_ff       <= sq;
   end

   assign status.rows_nz    = (n_rows_ff != '0);
   assign status.close_row  = close_ff;
   assign status.idx_last   = (CNT_W'(idx_ff) == (n_rows_ff - CNT_W'(1)));
   assign status.pipe_empty = !v0_ff && !v1_ff;

   assign rsp_valid        = valid_ff;
   assign rsp_lag          = lag_ff;
   assign rsp_semivariance = sv_ff;
   assign rsp_run_last     = run_last_ff;

endmodule

`default_nettype wire

// File: sv/variogram_pair_emitter.sv
// variogram_pair_emitter: top level, controller plus datapath
// depends on vpe_pkg, vpe_ctrl, vpe_dp (and vpe_ram below it)
//
//  channel   handshake              payload
//  -------   ---------------------  --------------------------------------------
//  request   start, busy            req_sample_time, req_sample_value,
//                                   req_has_sample, req_subject_end
//  response  rsp_valid (1 cycle)    rsp_lag, rsp_semivariance, rsp_run_last
//
//  a request transaction with a sample and k earlier samples stored gives k rows,
//  one per cycle while the store is not full; busy is high in the decide state,
//  in the issue state for one store read per row, and in the drain state while
//  store read register and the two stages behind it drain; a closing (0,0) row
//  goes from decide to drain; a transaction with no rows is busy in decide only
//  synchronous active high reset clears the state machine, count and strobes;
//  the stores need no clearing, only written entries are read
//  the receiver cannot stall: each row is shown for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module variogram_pair_emitter
   import vpe_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic signed [TIME_W-1:0] req_sample_time,
   input  wire logic signed [VAL_W-1:0]  req_sample_value,
   input  wire logic                     req_has_sample,
   input  wire logic                     req_subject_end,
   output logic                          rsp_valid,
   output logic             [LAG_W-1:0]  rsp_lag,
   output logic             [SV_W-1:0]   rsp_semivariance,
   output logic                          rsp_run_last
);

   // commands from the sequencer, status back from the datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: accept, decide between pair rows / closing row / nothing,
   // step the read index, then wait for the pipeline to drain
   vpe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // datapath: sample stores, count, read index, abs difference and square
   vpe_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample_time  (req_sample_time),
      .req_sample_value (req_sample_value),
      .req_has_sample   (req_has_sample),
      .req_subject_end  (req_subject_end),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_lag          (rsp_lag),
      .rsp_semivariance (rsp_semivariance),
      .rsp_run_last     (rsp_run_last)
   );

`ifndef ASSERT_OFF
   // rows of one transaction come out back to back
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |=> rsp_valid)
      else $error("row run broken before its last row");

   // a pair row is only read when the taken request has pair rows
   a_issue_has_rows: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status.rows_nz)
      else $error("store read issued with no pair rows");

   // an accepted transaction keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // the closing row always carries zeros
   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.issue_zero |-> ##3 (rsp_valid && rsp_run_last && rsp_lag == '0
         && rsp_semivariance == '0))
      else $error("closing row not zero");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for the variogram pair emitter
// depends on vpe_pkg and the variogram_pair_emitter RTL; a small class predicts the rows
`timescale 1ns / 1ps

module tb_top
   import vpe_pkg::*;
();

   // row predictor and score: keeps its own copy of the subject store
   class pair_row_board;
      typedef struct {
         bit [LAG_W-1:0] lag;
         bit [SV_W-1:0]  semi;
         bit             last;
      } pair_row_type;

      pair_row_type     rows_due[$];
      bit [TIME_W-1:0]  times[MAX_SAMPLES];
      bit [VAL_W-1:0]   vals[MAX_SAMPLES];
      int               held;
      int               errors, items, samples, dropped, closes, rows_seen;

      // work out the rows one request transaction causes
      function void take_request(bit [TIME_W-1:0] t, bit [VAL_W-1:0] y, bit has, bit fin);
         pair_row_type r;
         longint       dt, dy;
         int           first;
         first = rows_due.size();
         items++;
         if (has && held < MAX_SAMPLES) begin
            for (int j = 0; j < held; j++) begin
               dt = longint'($signed(times[j])) - longint'($signed(t));
               dy = longint'($signed(vals[j])) - longint'($signed(y));
               if (dt < 0) dt = -dt;
               if (dy < 0) dy = -dy;
               r.lag  = LAG_W'(dt);
               r.semi = SV_W'(dy * dy);
               r.last = 1'b0;
               rows_due.push_back(r);
            end
            times[held] = t;
            vals[held]  = y;
            held++;
            samples++;
         end else if (has) begin
            dropped++;
         end
         if (fin) begin
            if (held <= 1) begin
               r.lag  = '0;
               r.semi = '0;
               r.last = 1'b0;
               rows_due.push_back(r);
            end
            held = 0;
            closes++;
         end
         if (rows_due.size() > first) begin
            r = rows_due.pop_back();
            r.last = 1'b1;
            rows_due.push_back(r);
         end
      endfunction

      function void check_row(bit [LAG_W-1:0] lag, bit [SV_W-1:0] semi, bit last);
         pair_row_type r;
         rows_seen++;
         if (rows_due.size() == 0) begin
            errors++;
            $display("%0t unexpected row: lag %h semivariance %h run_last %b",
                     $time, lag, semi, last);
         end else begin
            r = rows_due.pop_front();
            if (r.lag !== lag || r.semi !== semi || r.last !== last) begin
               errors++;
               $display("%0t row mismatch: lag exp %h got %h, semivariance exp %h got %h,",
                        $time, r.lag, lag, r.semi, semi,
                        " run_last exp %b got %b", r.last, last);
            end
         end
      endfunction

      function int pending();
         return rows_due.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [TIME_W-1:0] req_sample_time  = '0;
   logic signed [VAL_W-1:0]  req_sample_value = '0;
   logic                     req_has_sample   = 1'b0;
   logic                     req_subject_end  = 1'b0;
   logic                     rsp_valid;
   logic [LAG_W-1:0]         rsp_lag;
   logic [SV_W-1:0]          rsp_semivariance;
   logic                     rsp_run_last;

   pair_row_board book;
   bit            idle_ok = 1'b1;   // cleared for the stretch without gaps

   always #6 clock = ~clock;

   variogram_pair_emitter u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_time  (req_sample_time),
      .req_sample_value (req_sample_value),
      .req_has_sample   (req_has_sample),
      .req_subject_end  (req_subject_end),
      .rsp_valid        (rsp_valid),
      .rsp_lag          (rsp_lag),
      .rsp_semivariance (rsp_semivariance),
      .rsp_run_last     (rsp_run_last)
   );

   // rows are strobed for one cycle; take them at the edge that ends that cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) book.check_row(rsp_lag, rsp_semivariance, rsp_run_last);
   end

   // one request transaction: optional random gap, then hold start until busy is low
   // at an edge; start stays high afterwards so back-to-back requests need no toggle
   task automatic send_item(input logic [TIME_W-1:0] t, input logic [VAL_W-1:0] y,
                            input logic has, input logic fin);
      int gap;
      if (idle_ok && $urandom_range(99) < 17) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_sample_time  <= t;
      req_sample_value <= y;
      req_has_sample   <= has;
      req_subject_end  <= fin;
      do @(posedge clock); while (busy);
      book.take_request(t, y, has, fin);
   endtask

   // sender holds off until every predicted row has come out
   task automatic drain_pause();
      start <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   // generous cap on the whole run
   initial begin
      #1_500_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int               rand_items, subj, size, waited;
      bit               close_on_sample;
      logic [TIME_W-1:0] tbase, t;
      logic [VAL_W-1:0]  y;

      book = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: idle item, empty close, single-sample subjects, field extremes
      send_item(32'h0000_0000, 24'h00_0000, 1'b0, 1'b0);   // idle, no rows
      send_item(32'h0000_0000, 24'h00_0000, 1'b0, 1'b1);   // empty subject closes
      send_item(32'h0001_0000, 24'h00_1000, 1'b1, 1'b1);   // one sample closing itself
      send_item(32'h7FFF_FFFF, 24'h7F_FFFF, 1'b1, 1'b0);
      send_item(32'h0000_0000, 24'h00_0000, 1'b0, 1'b1);   // close without sample, one held
      send_item(32'h7FFF_FFFF, 24'h7F_FFFF, 1'b1, 1'b0);
      send_item(32'h8000_0000, 24'h80_0000, 1'b1, 1'b0);   // widest lag and difference
      send_item(32'h8000_0000, 24'h7F_FFFF, 1'b1, 1'b0);
      send_item(32'h7FFF_FFFF, 24'h80_0000, 1'b1, 1'b0);
      send_item(32'h7FFF_FFFF, 24'h7F_FFFF, 1'b1, 1'b0);   // repeats first sample, zero row
      send_item(32'h0000_0000, 24'h00_0000, 1'b1, 1'b1);   // pairs then close, no (0,0) row
      send_item(32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b0);
      send_item(32'h0000_0001, 24'h00_0001, 1'b1, 1'b0);
      send_item(32'h0000_0000, 24'h00_0000, 1'b0, 1'b1);   // close with two held, no rows
      send_item(32'h1234_5678, 24'h0A_BCDE, 1'b1, 1'b0);
      send_item(32'hDEAD_BEEF, 24'h5A_A5A5, 1'b0, 1'b0);   // idle with junk payload
      send_item(32'h0000_0000, 24'h00_0000, 1'b0, 1'b1);   // one held, (0,0) row
      drain_pause();

      // random subjects: mostly small, the third one overfills the store
      rand_items = 0;
      subj       = 0;
      tbase      = $urandom;
      while (rand_items < 105) begin
         size            = (subj == 2) ? MAX_SAMPLES + $urandom_range(1, 3)
                                       : $urandom_range(0, 6);
         close_on_sample = 1'($urandom_range(1));
         for (int s = 0; s < size; s++) begin
            idle_ok = !(rand_items >= 30 && rand_items < 75);
            if ($urandom_range(9) == 0) begin
               send_item($urandom, 24'($urandom), 1'b0, 1'b0);
               rand_items++;
            end
            case ($urandom_range(3))
               0:       t = $urandom;
               1:       t = {($urandom_range(1) ? 16'h7FFF : 16'h8000), 16'($urandom)};
               default: begin
                  tbase = tbase + $urandom_range(1, 32'h0004_0000);
                  t     = tbase;
               end
            endcase
            case ($urandom_range(2))
               0:       y = 24'($urandom);
               1:       y = {($urandom_range(1) ? 4'h7 : 4'h8), 20'($urandom)};
               default: y = 24'($urandom_range(0, 8192) - 4096);
            endcase
            send_item(t, y, 1'b1, close_on_sample && s == size - 1);
            rand_items++;
         end
         if (!close_on_sample || size == 0) begin
            send_item($urandom, 24'($urandom), 1'b0, 1'b1);
            rand_items++;
         end
         // noise: any mix of flags with random payload
         if ($urandom_range(7) == 0) begin
            send_item($urandom, 24'($urandom), 1'($urandom), 1'($urandom));
            rand_items++;
         end
         subj++;
         if (subj == 6) drain_pause();
      end
      start <= 1'b0;

      // wait for the last rows, then let the pipeline settle
      waited = 0;
      while (book.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (book.pending() != 0) begin
         book.errors++;
         $display("%0t %0d predicted rows never came out", $time, book.pending());
      end

      $display("covered %0d transactions: %0d samples stored, %0d dropped at full store,",
               book.items, book.samples, book.dropped, " %0d subjects closed", book.closes);
      $display("checked %0d rows, %0d errors", book.rows_seen, book.errors);
      if (book.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/vpe_pkg.sv
sv/vpe_ram.sv
sv/vpe_ctrl.sv
sv/vpe_dp.sv
sv/variogram_pair_emitter.sv
tb/tb_top.sv
